>>> src/flow_key_header_parser_macros.svh
// Assertion macros used by the checker file.
`ifndef FLOW_KEY_HEADER_PARSER_MACROS_SVH
`define FLOW_KEY_HEADER_PARSER_MACROS_SVH
`define FKH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FKH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/fkhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fkhp_pkg;
	localparam logic [15:0] EgressCapReset = 16'd1514;
	localparam logic [15:0] EtypeVlanQ  = 16'h8100;
	localparam logic [15:0] EtypeVlanAd = 16'h88A8;
	localparam logic [15:0] EtypeIpv4   = 16'h0800;
	localparam logic [15:0] EtypeIpv6   = 16'h86DD;
	localparam logic [7:0]  ProtoTcp    = 8'd6;
	localparam logic [7:0]  ProtoUdp    = 8'd17;

	typedef enum logic [2:0] {
		ST_ETH, ST_VLAN, ST_IPV4, ST_IPV4_OPT, ST_IPV6, ST_L4, ST_DONE
	} stage_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        last_byte;
		logic        ingress;
		logic [15:0] frame_len;
	} in_word_t;

	typedef struct packed {
		logic        counted;
		logic [2:0]  ip_version;
		logic [47:0] client_eth_addr;
		logic [63:0] client_ip_high;
		logic [63:0] client_ip_low;
		logic [63:0] remote_ip_high;
		logic [63:0] remote_ip_low;
		logic [15:0] peer_port;
		logic [15:0] client_port;
		logic [7:0]  ip_protocol;
		logic [15:0] byte_count;
		logic        direction;
	} out_word_t;
endpackage
`default_nettype wire

>>> src/fkhp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fkhp_stream_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/flow_key_header_parser.sv
// The accepted last byte of a frame is registered in w_s1, and its record word then in od_q.
// Throughput: one byte word per cycle while the output register is not stalled, with no gaps between frames.
// A record waits in an output register; input stalls only while both are full.
// Reset (arst_n low) clears all parse state and sets the egress cap to 1514.
`timescale 1ns / 1ps
`default_nettype none
module flow_key_header_parser #(
	parameter logic [15:0] CAP_RESET = fkhp_pkg::EgressCapReset
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fkhp_stream_if.sink       in_if,
	fkhp_stream_if.source     out_if,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata
);
	import fkhp_pkg::*;

	logic [15:0] cap_q;
	logic        v_s1;
	in_word_t    w_s1;
	logic        adv;

	logic [15:0] off_q, sec_q;
	stage_t      stg_q;
	logic        drop_q, pc_q;
	logic [47:0] dmac_q, smac_q;
	logic [15:0] et_q;
	logic [1:0]  vcnt_q;
	logic [63:0] sip0_q, sip1_q, dip0_q, dip1_q;
	logic [7:0]  prot_q;
	logic [5:0]  hl_q;
	logic [15:0] sp_q, dp_q;

	logic        ov_q;
	out_word_t   od_q;

	assign adv = !ov_q || out_if.ready;
	assign in_if.ready = adv || !v_s1;
	assign out_if.valid = ov_q;
	assign out_if.data = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_if.ready) begin
			v_s1 <= in_if.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_if.ready && in_if.valid) begin
			w_s1 <= in_if.data;
		end
	end

	// Next-state values of the per-frame parse registers.
	logic [15:0] rel, nxt;
	logic [7:0]  b;
	stage_t      stg_d;
	logic        drop_d, pc_d;
	logic [47:0] dmac_d, smac_d;
	logic [15:0] et_d, sec_d, sp_d, dp_d;
	logic [1:0]  vcnt_d;
	logic [63:0] sip0_d, sip1_d, dip0_d, dip1_d;
	logic [7:0]  prot_d;
	logic [5:0]  hl_d;
	logic        bad_mac, bad_ip4, etype_vlan;
	logic [31:0] s4, d4;
	logic [47:0] dm_n, sm_n;
	logic [15:0] et_n;
	logic [5:0]  l4_len;

	function automatic logic mac_bad(input logic [47:0] m);
		mac_bad = (m == '0) || (m == '1) || m[40];
	endfunction

	function automatic logic ip4_bad(input logic [31:0] a);
		ip4_bad = (a == '0) || (a == '1) || (a[31:28] == 4'he);
	endfunction

	always_comb begin
		b = w_s1.frame_byte;
		rel = off_q - sec_q;
		nxt = off_q + 16'd1;
		stg_d = stg_q; drop_d = drop_q; pc_d = pc_q;
		dmac_d = dmac_q; smac_d = smac_q; et_d = et_q; sec_d = sec_q;
		vcnt_d = vcnt_q; sip0_d = sip0_q; sip1_d = sip1_q;
		dip0_d = dip0_q; dip1_d = dip1_q; prot_d = prot_q; hl_d = hl_q;
		sp_d = sp_q; dp_d = dp_q;
		dm_n = {dmac_q[39:0], b};
		sm_n = {smac_q[39:0], b};
		et_n = {et_q[7:0], b};
		s4 = sip1_q[31:0];
		d4 = {dip1_q[23:0], b};
		bad_mac = mac_bad(dmac_q) || mac_bad(smac_q);
		bad_ip4 = ip4_bad(s4) || ip4_bad(d4);
		etype_vlan = ((et_n == EtypeVlanQ) || (et_n == EtypeVlanAd));
		l4_len = (prot_q == ProtoTcp) ? 6'd20 : 6'd8;
		unique case (stg_q)
			ST_ETH: begin
				if (rel < 16'd6) dmac_d = dm_n;
				else if (rel < 16'd12) smac_d = sm_n;
				else if (rel < 16'd14) et_d = et_n;
				if (rel == 16'd13) begin
					sec_d = nxt;
					if (bad_mac) begin
						drop_d = 1'b1; stg_d = ST_DONE;
					end else if (etype_vlan) stg_d = ST_VLAN;
					else if (et_n == EtypeIpv4) stg_d = ST_IPV4;
					else if (et_n == EtypeIpv6) stg_d = ST_IPV6;
					else begin
						drop_d = 1'b1; stg_d = ST_DONE;
					end
				end
			end
			ST_VLAN: begin
				if (rel == 16'd2 || rel == 16'd3) et_d = et_n;
				if (rel == 16'd3) begin
					vcnt_d = vcnt_q + 2'd1;
					sec_d = nxt;
					if (etype_vlan && vcnt_q == 2'd0) stg_d = ST_VLAN;
					else if (et_n == EtypeIpv4) stg_d = ST_IPV4;
					else if (et_n == EtypeIpv6) stg_d = ST_IPV6;
					else begin
						drop_d = 1'b1; stg_d = ST_DONE;
					end
				end
			end
			ST_IPV4: begin
				if (rel == 16'd0) hl_d = {b[3:0], 2'b00};
				else if (rel == 16'd9) prot_d = b;
				else if (rel >= 16'd12 && rel < 16'd16) sip1_d = {32'd0, s4[23:0], b};
				else if (rel >= 16'd16 && rel < 16'd20) dip1_d = {32'd0, d4};
				if (rel == 16'd19) begin
					if (bad_ip4 || hl_q < 6'd20) begin
						drop_d = 1'b1; stg_d = ST_DONE;
					end else if (hl_q == 6'd20) begin
						sec_d = nxt;
						stg_d = ((prot_q == ProtoTcp) || (prot_q == ProtoUdp)) ? ST_L4 : ST_DONE;
					end else stg_d = ST_IPV4_OPT;
				end
			end
			ST_IPV4_OPT: begin
				if ((rel + 16'd1) >= {10'd0, hl_q}) begin
					sec_d = nxt;
					stg_d = ((prot_q == ProtoTcp) || (prot_q == ProtoUdp)) ? ST_L4 : ST_DONE;
				end
			end
			ST_IPV6: begin
				if (rel == 16'd6) prot_d = b;
				else if (rel >= 16'd8 && rel < 16'd16) sip0_d = {sip0_q[55:0], b};
				else if (rel >= 16'd16 && rel < 16'd24) sip1_d = {sip1_q[55:0], b};
				else if (rel >= 16'd24 && rel < 16'd32) dip0_d = {dip0_q[55:0], b};
				else if (rel >= 16'd32 && rel < 16'd40) dip1_d = {dip1_q[55:0], b};
				if (rel == 16'd39) begin
					if (sip0_q[63:56] == 8'hff || dip0_q[63:56] == 8'hff) begin
						drop_d = 1'b1; stg_d = ST_DONE;
					end else begin
						sec_d = nxt;
						stg_d = ((prot_q == ProtoTcp) || (prot_q == ProtoUdp)) ? ST_L4 : ST_DONE;
					end
				end
			end
			ST_L4: begin
				if (rel < 16'd2) sp_d = {sp_q[7:0], b};
				else if (rel < 16'd4) dp_d = {dp_q[7:0], b};
				if ((rel + 16'd1) >= {10'd0, l4_len}) begin
					pc_d = 1'b1; stg_d = ST_DONE;
				end
			end
			default: ;
		endcase
	end

	logic do_step;
	assign do_step = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; sec_q <= '0; stg_q <= ST_ETH; drop_q <= 1'b0; pc_q <= 1'b0;
			dmac_q <= '0; smac_q <= '0; et_q <= '0; vcnt_q <= '0;
			sip0_q <= '0; sip1_q <= '0; dip0_q <= '0; dip1_q <= '0;
			prot_q <= '0; hl_q <= '0; sp_q <= '0; dp_q <= '0;
		end else if (do_step) begin
			if (w_s1.last_byte) begin
				off_q <= '0; sec_q <= '0; stg_q <= ST_ETH; drop_q <= 1'b0; pc_q <= 1'b0;
				dmac_q <= '0; smac_q <= '0; et_q <= '0; vcnt_q <= '0;
				sip0_q <= '0; sip1_q <= '0; dip0_q <= '0; dip1_q <= '0;
				prot_q <= '0; hl_q <= '0; sp_q <= '0; dp_q <= '0;
			end else begin
				off_q <= (off_q == 16'hffff) ? off_q : nxt;
				sec_q <= sec_d; stg_q <= stg_d; drop_q <= drop_d; pc_q <= pc_d;
				dmac_q <= dmac_d; smac_q <= smac_d; et_q <= et_d; vcnt_q <= vcnt_d;
				sip0_q <= sip0_d; sip1_q <= sip1_d; dip0_q <= dip0_d; dip1_q <= dip1_d;
				prot_q <= prot_d; hl_q <= hl_d; sp_q <= sp_d; dp_q <= dp_d;
			end
		end
	end

	out_word_t rec;
	logic      cnt, ing;
	logic [15:0] spx, dpx, flen;

	always_comb begin
		ing = w_s1.ingress;
		flen = w_s1.frame_len;
		cnt = !drop_d && (stg_d == ST_IPV4_OPT || stg_d == ST_L4 || stg_d == ST_DONE);
		spx = pc_d ? sp_d : 16'd0;
		dpx = pc_d ? dp_d : 16'd0;
		rec = '0;
		if (cnt) begin
			rec.counted = 1'b1;
			rec.ip_version = (et_d == EtypeIpv6) ? 3'd6 : 3'd4;
			rec.client_eth_addr = ing ? smac_d : dmac_d;
			rec.client_ip_high = ing ? sip0_d : dip0_d;
			rec.client_ip_low = ing ? sip1_d : dip1_d;
			rec.remote_ip_high = ing ? dip0_d : sip0_d;
			rec.remote_ip_low = ing ? dip1_d : sip1_d;
			rec.peer_port = ing ? dpx : spx;
			rec.client_port = ing ? spx : dpx;
			rec.ip_protocol = prot_d;
			rec.byte_count = (ing || flen <= cap_q) ? flen : cap_q;
			rec.direction = ing;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= v_s1 && w_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && w_s1.last_byte) begin
			od_q <= rec;
		end
	end
endmodule
`default_nettype wire

>>> src/fkhp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "flow_key_header_parser_macros.svh"
module fkhp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire fkhp_pkg::out_word_t out_data
);
	import fkhp_pkg::*;

	`FKH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "record word changed while stalled")
	`FKH_ASSERT_IMP(a_drop_zero, out_valid && !out_data.counted, out_data.ip_version == 3'd0 && out_data.byte_count == 16'd0, "dropped record not zero")
	`FKH_ASSERT_IMP(a_version, out_valid && out_data.counted, out_data.ip_version == 3'd4 || out_data.ip_version == 3'd6, "counted record has bad version")
	`FKH_ASSERT_IMP(a_ready_free, !out_valid, in_ready, "input stalled with empty output")
endmodule

bind flow_key_header_parser fkhp_checker u_fkhp_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_if.valid), .in_ready(in_if.ready),
	.out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

>>> test/flow_key_header_parser_tb.sv
`timescale 1ns / 1ps
module flow_key_header_parser_tb;
	import fkhp_pkg::*;

	typedef enum int {FLAW_NONE, FLAW_MAC_ZERO, FLAW_MAC_BCAST, FLAW_MAC_MCAST, FLAW_IP} flaw_t;

	typedef struct {
		int          vlans;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		flaw_t       flaw;
		int          cut;
		bit          ing;
		logic [15:0] flen;
		bit          typed_drop;
	} frame_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	fkhp_stream_if #(.word_t(in_word_t)) in_if ();
	fkhp_stream_if #(.word_t(out_word_t)) out_if ();

	flow_key_header_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_if(in_if),
		.out_if(out_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the parser state.
	logic [15:0] cap_shadow;
	logic [15:0] p_off;
	stage_t      p_stage;
	logic        p_drop;
	logic [47:0] p_dmac;
	logic [47:0] p_smac;
	logic [15:0] p_etype;
	logic [1:0]  p_tags;
	logic [15:0] p_sec;
	logic [63:0] p_sip [2];
	logic [63:0] p_dip [2];
	logic [7:0]  p_proto;
	logic [7:0]  p_hlen;
	logic [15:0] p_sport;
	logic [15:0] p_dport;
	logic        p_pdone;

	out_word_t   record_q [$];
	bit          drop_typed_q [$];
	logic [7:0]  frame_bytes [$];

	int errors = 0;
	int words_sent = 0;
	int frames_sent = 0;
	int records_seen = 0;
	int drops_seen = 0;
	int cycles = 0;
	bit idle_on = 1;
	int out_stall = 0;

	function automatic bit bad_mac(logic [47:0] m);
		return m == 48'd0 || m == 48'hFFFF_FFFF_FFFF || m[40];
	endfunction

	function automatic bit bad_ip4(logic [63:0] a);
		return a == 64'd0 || a == 64'hFFFF_FFFF || (a & 64'hF000_0000) == 64'hE000_0000;
	endfunction

	task automatic clear_shadow();
		p_off = '0;
		p_stage = ST_ETH;
		p_drop = 1'b0;
		p_dmac = '0;
		p_smac = '0;
		p_etype = '0;
		p_tags = '0;
		p_sec = '0;
		p_sip[0] = '0;
		p_sip[1] = '0;
		p_dip[0] = '0;
		p_dip[1] = '0;
		p_proto = '0;
		p_hlen = '0;
		p_sport = '0;
		p_dport = '0;
		p_pdone = 1'b0;
	endtask

	task automatic mark_drop();
		p_drop = 1'b1;
		p_stage = ST_DONE;
	endtask

	task automatic pick_link_next(logic [15:0] nxt);
		p_sec = nxt;
		if ((p_etype == EtypeVlanQ || p_etype == EtypeVlanAd) && p_tags < 2'd2) begin
			p_stage = ST_VLAN;
		end else if (p_etype == EtypeIpv4) begin
			p_stage = ST_IPV4;
		end else if (p_etype == EtypeIpv6) begin
			p_stage = ST_IPV6;
		end else begin
			mark_drop();
		end
	endtask

	task automatic start_transport(logic [15:0] nxt);
		p_sec = nxt;
		p_stage = (p_proto == ProtoTcp || p_proto == ProtoUdp) ? ST_L4 : ST_DONE;
	endtask

	task automatic predict_flow_key(input in_word_t w, output bit has, output out_word_t r);
		logic [15:0] rel;
		logic [15:0] nxt;
		logic [7:0]  b;
		logic [15:0] sp;
		logic [15:0] dp;
		b = w.frame_byte;
		rel = p_off - p_sec;
		nxt = p_off + 16'd1;
		has = 1'b0;
		r = '0;
		case (p_stage)
			ST_ETH: begin
				if (rel < 6) p_dmac = {p_dmac[39:0], b};
				else if (rel < 12) p_smac = {p_smac[39:0], b};
				else if (rel < 14) p_etype = {p_etype[7:0], b};
				if (rel == 13) begin
					if (bad_mac(p_dmac) || bad_mac(p_smac)) mark_drop();
					else pick_link_next(nxt);
				end
			end
			ST_VLAN: begin
				if (rel == 2 || rel == 3) p_etype = {p_etype[7:0], b};
				if (rel == 3) begin
					p_tags = p_tags + 2'd1;
					pick_link_next(nxt);
				end
			end
			ST_IPV4: begin
				if (rel == 0) p_hlen = {2'b00, b[3:0], 2'b00};
				else if (rel == 9) p_proto = b;
				else if (rel >= 12 && rel < 16) p_sip[1] = {32'd0, p_sip[1][23:0], b};
				else if (rel >= 16 && rel < 20) p_dip[1] = {32'd0, p_dip[1][23:0], b};
				if (rel == 19) begin
					if (bad_ip4(p_sip[1]) || bad_ip4(p_dip[1]) || p_hlen < 20) mark_drop();
					else if (p_hlen == 20) start_transport(nxt);
					else p_stage = ST_IPV4_OPT;
				end
			end
			ST_IPV4_OPT: begin
				if (32'(rel) + 1 >= 32'(p_hlen)) start_transport(nxt);
			end
			ST_IPV6: begin
				if (rel == 6) p_proto = b;
				else if (rel >= 8 && rel < 16) p_sip[0] = {p_sip[0][55:0], b};
				else if (rel >= 16 && rel < 24) p_sip[1] = {p_sip[1][55:0], b};
				else if (rel >= 24 && rel < 32) p_dip[0] = {p_dip[0][55:0], b};
				else if (rel >= 32 && rel < 40) p_dip[1] = {p_dip[1][55:0], b};
				if (rel == 39) begin
					if (p_sip[0][63:56] == 8'hFF || p_dip[0][63:56] == 8'hFF) mark_drop();
					else start_transport(nxt);
				end
			end
			ST_L4: begin
				if (rel < 2) p_sport = {p_sport[7:0], b};
				else if (rel < 4) p_dport = {p_dport[7:0], b};
				if (32'(rel) + 1 >= (p_proto == ProtoTcp ? 20 : 8)) begin
					p_pdone = 1'b1;
					p_stage = ST_DONE;
				end
			end
			default: ;
		endcase
		if (p_off != 16'hFFFF) p_off = p_off + 16'd1;
		if (w.last_byte) begin
			has = 1'b1;
			if (!p_drop && (p_stage == ST_IPV4_OPT || p_stage == ST_L4 || p_stage == ST_DONE)) begin
				sp = p_pdone ? p_sport : 16'd0;
				dp = p_pdone ? p_dport : 16'd0;
				r.counted = 1'b1;
				r.ip_version = (p_etype == EtypeIpv6) ? 3'd6 : 3'd4;
				r.client_eth_addr = w.ingress ? p_smac : p_dmac;
				r.client_ip_high = w.ingress ? p_sip[0] : p_dip[0];
				r.client_ip_low = w.ingress ? p_sip[1] : p_dip[1];
				r.remote_ip_high = w.ingress ? p_dip[0] : p_sip[0];
				r.remote_ip_low = w.ingress ? p_dip[1] : p_sip[1];
				r.peer_port = w.ingress ? dp : sp;
				r.client_port = w.ingress ? sp : dp;
				r.ip_protocol = p_proto;
				r.byte_count = (w.ingress || w.frame_len <= cap_shadow) ? w.frame_len : cap_shadow;
				r.direction = w.ingress;
			end
			clear_shadow();
		end
	endtask

	function automatic logic [47:0] good_mac();
		logic [47:0] m;
		m = 48'({$urandom, $urandom});
		m[40] = 1'b0;
		if (m == 48'd0) m = 48'h0200_0000_0001;
		return m;
	endfunction

	function automatic logic [31:0] good_ip4();
		logic [31:0] a;
		a = $urandom;
		if (a == 32'd0 || a == 32'hFFFF_FFFF || a[31:28] == 4'hE) a[31:28] = 4'h1;
		return a;
	endfunction

	task automatic push_bytes(logic [63:0] v, int n);
		for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[i*8 +: 8]);
	endtask

	task automatic build_frame(frame_row_t f);
		logic [47:0] dmac;
		logic [47:0] smac;
		logic [31:0] a4 [2];
		logic [63:0] a6 [4];
		bit          bad_side;
		int          l4_len;
		frame_bytes.delete();
		dmac = good_mac();
		smac = good_mac();
		bad_side = 1'($urandom_range(0, 1));
		case (f.flaw)
			FLAW_MAC_ZERO: if (bad_side) dmac = '0; else smac = '0;
			FLAW_MAC_BCAST: if (bad_side) dmac = '1; else smac = '1;
			FLAW_MAC_MCAST: if (bad_side) dmac[40] = 1'b1; else smac[40] = 1'b1;
			default: ;
		endcase
		push_bytes(64'(dmac), 6);
		push_bytes(64'(smac), 6);
		for (int t = 0; t < f.vlans; t++) begin
			push_bytes(64'((t % 2) ? EtypeVlanAd : EtypeVlanQ), 2);
			push_bytes(64'($urandom), 2);
		end
		push_bytes(64'(f.etype), 2);
		if (f.etype == EtypeIpv4) begin
			a4[0] = good_ip4();
			a4[1] = good_ip4();
			if (f.flaw == FLAW_IP) begin
				case ($urandom_range(0, 2))
					0: a4[bad_side] = 32'd0;
					1: a4[bad_side] = 32'hFFFF_FFFF;
					default: a4[bad_side] = {4'hE, 28'($urandom)};
				endcase
			end
			frame_bytes.push_back({4'h4, f.ihl});
			push_bytes({$urandom, $urandom}, 8);
			frame_bytes.push_back(f.proto);
			push_bytes(64'($urandom), 2);
			push_bytes(64'(a4[0]), 4);
			push_bytes(64'(a4[1]), 4);
			for (int k = 20; k < 4 * f.ihl; k++) frame_bytes.push_back(8'($urandom));
		end else if (f.etype == EtypeIpv6) begin
			for (int k = 0; k < 4; k++) begin
				a6[k] = {$urandom, $urandom};
				if (a6[k][63:56] == 8'hFF) a6[k][63:56] = 8'h20;
			end
			if (f.flaw == FLAW_IP) a6[bad_side ? 2 : 0][63:56] = 8'hFF;
			frame_bytes.push_back({4'h6, 4'($urandom)});
			push_bytes(64'($urandom), 5);
			frame_bytes.push_back(f.proto);
			frame_bytes.push_back(8'($urandom));
			for (int k = 0; k < 4; k++) push_bytes(a6[k], 8);
		end
		l4_len = (f.proto == ProtoTcp) ? 20 : (f.proto == ProtoUdp) ? 8 : $urandom_range(0, 8);
		for (int k = 0; k < l4_len + $urandom_range(0, 10); k++)
			frame_bytes.push_back(8'($urandom));
		if (f.cut > 0 && f.cut < frame_bytes.size())
			while (frame_bytes.size() > f.cut) void'(frame_bytes.pop_back());
	endtask

	task automatic send_frame(frame_row_t f);
		in_word_t w;
		int gap;
		drop_typed_q.push_back(f.typed_drop);
		foreach (frame_bytes[i]) begin
			gap = idle_on ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			w.frame_byte = frame_bytes[i];
			w.last_byte = (i == frame_bytes.size() - 1);
			w.ingress = w.last_byte ? f.ing : 1'($urandom_range(0, 1));
			w.frame_len = w.last_byte ? f.flen : 16'($urandom);
			in_if.valid <= 1'b1;
			in_if.data <= w;
			@(posedge clk iff in_if.ready);
		end
		frames_sent++;
	endtask

	task automatic settle();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (record_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cap(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_shadow = v;
		@(posedge clk);
	endtask

	function automatic frame_row_t random_frame();
		frame_row_t f;
		f.ing = 1'($urandom_range(0, 1));
		f.flen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1400, 1600)) : 16'($urandom);
		f.typed_drop = 1'b0;
		f.proto = ($urandom_range(0, 9) < 8) ? (($urandom_range(0, 1)) ? ProtoTcp : ProtoUdp)
			: 8'($urandom);
		if ($urandom_range(0, 99) < 75) begin
			f.vlans = $urandom_range(0, 2);
			f.etype = $urandom_range(0, 1) ? EtypeIpv4 : EtypeIpv6;
			f.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
			f.flaw = FLAW_NONE;
			f.cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 110) : -1;
		end else begin
			f.vlans = $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				0: f.etype = EtypeIpv4;
				1: f.etype = EtypeIpv6;
				2: f.etype = EtypeVlanQ;
				default: f.etype = 16'($urandom);
			endcase
			f.ihl = 4'($urandom);
			f.flaw = flaw_t'($urandom_range(0, 4));
			f.cut = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 80) : -1;
		end
		return f;
	endfunction

	task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		bit has;
		out_word_t r;
		if (arst_n && in_if.valid && in_if.ready) begin
			words_sent++;
			predict_flow_key(in_if.data, has, r);
			if (has) begin
				if (drop_typed_q.size() != 0 && drop_typed_q.pop_front()) r = '0;
				record_q.push_back(r);
			end
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		out_word_t a;
		int stall;
		stall = out_stall;
		if (arst_n && out_if.valid && out_if.ready) begin
			a = out_if.data;
			records_seen++;
			if (!a.counted) drops_seen++;
			if (record_q.size() == 0) begin
				$error("Record word arrived with none expected.");
				errors++;
			end else begin
				e = record_q.pop_front();
				check_field("counted", e.counted, a.counted);
				check_field("ip_version", e.ip_version, a.ip_version);
				check_field("client_eth_addr", e.client_eth_addr, a.client_eth_addr);
				check_field("client_ip_high", e.client_ip_high, a.client_ip_high);
				check_field("client_ip_low", e.client_ip_low, a.client_ip_low);
				check_field("remote_ip_high", e.remote_ip_high, a.remote_ip_high);
				check_field("remote_ip_low", e.remote_ip_low, a.remote_ip_low);
				check_field("peer_port", e.peer_port, a.peer_port);
				check_field("client_port", e.client_port, a.client_port);
				check_field("ip_protocol", e.ip_protocol, a.ip_protocol);
				check_field("byte_count", e.byte_count, a.byte_count);
				check_field("direction", e.direction, a.direction);
			end
			stall = idle_on ? $urandom_range(0, 11) : 0;
		end
		if (stall > 0) begin
			out_if.ready <= 1'b0;
			out_stall <= stall - 1;
		end else begin
			out_if.ready <= 1'b1;
			out_stall <= 0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	frame_row_t directed [] = '{
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, -1, 1'b1, 16'd0, 1'b0},
		'{0, EtypeIpv4, 4'd5, ProtoUdp, FLAW_NONE, -1, 1'b0, 16'hFFFF, 1'b0},
		'{0, EtypeIpv6, 4'd5, ProtoTcp, FLAW_NONE, -1, 1'b0, 16'd1514, 1'b0},
		'{0, EtypeIpv6, 4'd5, ProtoUdp, FLAW_NONE, -1, 1'b1, 16'hFFFF, 1'b0},
		'{0, EtypeIpv4, 4'd5, 8'd1, FLAW_NONE, -1, 1'b1, 16'd64, 1'b0},
		'{0, EtypeIpv4, 4'd15, ProtoTcp, FLAW_NONE, -1, 1'b0, 16'd1515, 1'b0},
		'{2, EtypeIpv4, 4'd5, ProtoUdp, FLAW_NONE, -1, 1'b1, 16'd100, 1'b0},
		'{1, EtypeIpv6, 4'd5, 8'd58, FLAW_NONE, -1, 1'b0, 16'd60, 1'b0},
		'{3, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, -1, 1'b1, 16'd80, 1'b1},
		'{0, 16'h1234, 4'd5, ProtoTcp, FLAW_NONE, -1, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_MAC_ZERO, -1, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_MAC_BCAST, -1, 1'b0, 16'd80, 1'b1},
		'{0, EtypeIpv6, 4'd5, ProtoTcp, FLAW_MAC_MCAST, -1, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoUdp, FLAW_IP, -1, 1'b0, 16'd80, 1'b1},
		'{0, EtypeIpv6, 4'd5, ProtoUdp, FLAW_IP, -1, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd4, ProtoTcp, FLAW_NONE, -1, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd0, ProtoTcp, FLAW_NONE, -1, 1'b0, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, 5, 1'b1, 16'd80, 1'b1},
		'{1, EtypeIpv6, 4'd5, ProtoTcp, FLAW_NONE, 17, 1'b1, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, 30, 1'b0, 16'd80, 1'b1},
		'{0, EtypeIpv6, 4'd5, ProtoTcp, FLAW_NONE, 50, 1'b0, 16'd80, 1'b1},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, 40, 1'b1, 16'd80, 1'b0},
		'{0, EtypeIpv4, 4'd8, ProtoTcp, FLAW_NONE, 36, 1'b0, 16'd80, 1'b0},
		'{0, EtypeIpv4, 4'd5, ProtoTcp, FLAW_NONE, 1, 1'b1, 16'd80, 1'b1}
	};

	initial begin
		logic [15:0] caps [4];
		frame_row_t f;
		int phase_base;
		caps = '{16'd0, 16'hFFFF, 16'($urandom), EgressCapReset};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		out_if.ready = 1'b0;
		cap_shadow = EgressCapReset;
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			build_frame(directed[i]);
			send_frame(directed[i]);
		end
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			write_cap(caps[phase]);
			idle_on = (phase != 2);
			phase_base = words_sent;
			while (words_sent < phase_base + 110) begin
				f = random_frame();
				build_frame(f);
				send_frame(f);
				if (phase == 1 && frames_sent % 20 == 0) settle();
			end
			settle();
		end

		idle_on = 0;
		f = random_frame();
		f.cut = -1;
		f.flaw = FLAW_NONE;
		f.vlans = 0;
		f.etype = EtypeIpv4;
		f.ihl = 4'd5;
		build_frame(f);
		while (frame_bytes.size() < 200) frame_bytes.push_back(8'($urandom));
		send_frame(f);
		settle();
		repeat (20) @(posedge clk);

		$display("Sent %0d frames (%0d bytes) under four egress caps, including VLAN, option,",
			frames_sent, words_sent);
		$display("truncation, bad address and long frames; %0d records, %0d dropped.",
			records_seen, drops_seen);
		if (errors == 0 && record_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+src
src/fkhp_pkg.sv
src/fkhp_stream_if.sv
src/flow_key_header_parser.sv
src/fkhp_checker.sv
test/flow_key_header_parser_tb.sv
